>>> sv/rfb_pkg.sv
`default_nettype none

package rfb_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 1024;
    localparam int EVENT_BITS_DEF = 64;
    localparam int MAX_BATCH_DEF  = 64;

    // Fixed field widths
    localparam int SLOT_W  = 11;
    localparam int DATA_W  = 64;
    localparam int BATCH_W = 7;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 10;

    localparam logic [SLOT_W-1:0] SLOT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BATCH = 2'd2,
        OP_CLEAR = 2'd3
    } rfb_op_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_RDATA = 1'b1
    } rfb_state_t;

    typedef struct packed {
        rfb_op_t              operation;
        logic [DATA_W-1:0]    write_data;
        logic [BATCH_W-1:0]   batch_count;
    } rfb_in_t;

    typedef struct packed {
        logic                 ok;
        logic [DATA_W-1:0]    read_data;
        logic                 last;
        logic [INDEX_W-1:0]   batch_index;
        logic [COUNT_W-1:0]   filled_count;
        logic [COUNT_W-1:0]   free_count;
    } rfb_out_t;

    // Slot count clamped to [2, depth]
    function automatic int cap_clamp(input logic [SLOT_W-1:0] slots, input int depth);
        int c;
        c = int'(slots);
        if (c < 2) begin
            c = 2;
        end
        if (c > depth) begin
            c = depth;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/ring_fifo_buffer_unit.sv
`default_nettype none

// Results: write, clear and any failed operation return their result in the cycle after accept;
//   a read or batch event passes the synchronous store read register, then the output register.
// Throughput: writes/clears 1 transaction per cycle unless out_ready stalls; a read or batch
//   blocks new operations until done; a batch streams 1 event per cycle after the first unless stalled.
// Reset (rst_n, async low): positions and fill count clear, slot count goes to 1024
//   (clamped to DEPTH); store contents are undefined until written.
module ring_fifo_buffer_unit
    import rfb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int EVENT_BITS = EVENT_BITS_DEF,
    parameter int MAX_BATCH  = MAX_BATCH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: slot count
    input  wire logic              cfg_wr_en,
    input  wire logic [SLOT_W-1:0] cfg_wr_data,
    // operation channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rfb_in_t           in_data,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rfb_out_t               out_data
);

    // Position width and count/capacity width (capacity can equal DEPTH)
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] CAP_RESET = CW'(cap_clamp(SLOT_RESET, DEPTH));
    localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(MAX_BATCH);

    // Event store: one write port, one registered read port
    logic [EVENT_BITS-1:0] mem [DEPTH];
    logic [EVENT_BITS-1:0] mem_rd_reg;
    logic                  mem_we;
    logic                  mem_re;

    rfb_state_t         state_reg, state_next;
    logic [PW-1:0]      wr_pos_reg, wr_pos_next;
    logic [PW-1:0]      rd_pos_reg, rd_pos_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cap_reg, cap_next;
    logic [BATCH_W-1:0] want_reg, want_next;
    logic [INDEX_W-1:0] got_reg, got_next;
    logic               last_pend_reg, last_pend_next;
    logic               out_valid_reg, out_valid_next;
    rfb_out_t           out_data_reg, out_data_next;

    logic               out_free;
    logic               accept;
    logic               is_empty;
    logic               is_full;
    logic [CW-1:0]      wr_inc;
    logic [CW-1:0]      rd_inc;
    logic [PW-1:0]      wr_adv;
    logic [PW-1:0]      rd_adv;
    logic [BATCH_W-1:0] want_sat;
    logic [CW-1:0]      count_dec;

    // Output register frees up when empty or drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Fill state from the occupancy counter; full leaves one slot empty
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == cap_reg - CW'(1));
    assign count_dec = count_reg - CW'(1);

    // Wrap at the configured slot count
    assign wr_inc = CW'(wr_pos_reg) + CW'(1);
    assign rd_inc = CW'(rd_pos_reg) + CW'(1);
    assign wr_adv = (wr_inc >= cap_reg) ? '0 : wr_inc[PW-1:0];
    assign rd_adv = (rd_inc >= cap_reg) ? '0 : rd_inc[PW-1:0];

    assign want_sat = (in_data.batch_count > BATCH_MAX) ? BATCH_MAX : in_data.batch_count;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_empty && (
                    (in_data.operation == OP_READ) ||
                    ((in_data.operation == OP_BATCH) && (want_sat != '0))))
                begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:
            begin
                if (out_free && last_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result outputs
    always_comb
    begin
        wr_pos_next    = wr_pos_reg;
        rd_pos_next    = rd_pos_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        want_next      = want_reg;
        got_next       = got_reg;
        last_pend_next = last_pend_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // single-result default: failed, no data
                    out_valid_next             = 1'b1;
                    out_data_next.ok           = 1'b0;
                    out_data_next.read_data    = '0;
                    out_data_next.last         = 1'b1;
                    out_data_next.batch_index  = '0;
                    out_data_next.filled_count = COUNT_W'(count_reg);
                    out_data_next.free_count   = COUNT_W'(cap_reg - CW'(1) - count_reg);
                    unique case (in_data.operation)
                        OP_WRITE:
                        begin
                            if (!is_full)
                            begin
                                mem_we                     = 1'b1;
                                wr_pos_next                = wr_adv;
                                count_next                 = count_reg + CW'(1);
                                out_data_next.ok           = 1'b1;
                                out_data_next.filled_count = COUNT_W'(count_next);
                                out_data_next.free_count   =
                                    COUNT_W'(cap_reg - CW'(1) - count_next);
                            end
                        end
                        OP_READ:
                        begin
                            if (!is_empty)
                            begin
                                // result goes out once the store data is back
                                out_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                rd_pos_next    = rd_adv;
                                count_next     = count_dec;
                                want_next      = BATCH_W'(1);
                                got_next       = '0;
                                last_pend_next = 1'b1;
                            end
                        end
                        OP_BATCH:
                        begin
                            if (!is_empty && (want_sat != '0))
                            begin
                                out_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                rd_pos_next    = rd_adv;
                                count_next     = count_dec;
                                want_next      = want_sat;
                                got_next       = '0;
                                last_pend_next = (want_sat == BATCH_W'(1)) || (count_dec == '0);
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_pos_next                = '0;
                            rd_pos_next                = '0;
                            count_next                 = '0;
                            out_data_next.ok           = 1'b1;
                            out_data_next.filled_count = '0;
                            out_data_next.free_count   = COUNT_W'(cap_reg - CW'(1));
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDATA:
            begin
                if (out_free)
                begin
                    // count_reg already reflects the event being shown
                    out_valid_next             = 1'b1;
                    out_data_next.ok           = 1'b1;
                    out_data_next.read_data    = DATA_W'(mem_rd_reg);
                    out_data_next.last         = last_pend_reg;
                    out_data_next.batch_index  = got_reg;
                    out_data_next.filled_count = COUNT_W'(count_reg);
                    out_data_next.free_count   = COUNT_W'(cap_reg - CW'(1) - count_reg);
                    if (!last_pend_reg)
                    begin
                        // overlap: fetch the next batch event now
                        mem_re         = 1'b1;
                        rd_pos_next    = rd_adv;
                        count_next     = count_dec;
                        got_next       = got_reg + INDEX_W'(1);
                        last_pend_next = ((BATCH_W'(got_reg) + BATCH_W'(2)) == want_reg) ||
                                         (count_dec == '0);
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase

        // slot count write restarts the ring; write only while idle (the block does not enforce this)
        if (cfg_wr_en)
        begin
            cap_next    = CW'(cap_clamp(cfg_wr_data, DEPTH));
            wr_pos_next = '0;
            rd_pos_next = '0;
            count_next  = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        got_reg       <= got_next;
        last_pend_reg <= last_pend_next;
        out_data_reg  <= out_data_next;
    end

    // Event store; a write and a read never target the same cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_pos_reg] <= in_data.write_data[EVENT_BITS-1:0];
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[rd_pos_reg];
        end
    end

endmodule

`default_nettype wire
